// File: sv/s7s_pkg.sv
// shared types, constants and segment tables for the seven-segment serial unit
// no dependencies
`timescale 1ns / 1ps

package s7s_pkg;

    localparam int MAG_W        = 14;   // magnitude up to 9999
    localparam int DIGITS       = 4;
    localparam int SEG_W        = 8;
    localparam int FIFO_DEPTH   = 2;
    localparam int BITS_PER_ITEM = 64;
    localparam int CNT_W        = 6;

    localparam logic [SEG_W-1:0] SEG_BLANK      = 8'h00;
    localparam logic [SEG_W-1:0] SEG_MINUS      = 8'h40;
    localparam logic [SEG_W-1:0] SEG_UNDERSCORE = 8'h08;
    localparam logic [SEG_W-1:0] SEG_POINT      = 8'h80;

    localparam logic signed [31:0] VALUE_MAX = 32'sd9999;
    localparam logic signed [31:0] VALUE_MIN = -32'sd999;

    // reciprocal of ten scaled by 2^16, exact for magnitudes below 16384
    localparam logic [12:0] RECIP_TEN = 13'd6554;

    typedef logic [DIGITS-1:0][SEG_W-1:0] t_seg4;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_PUSH = 3'b100
    } t_front_state;

    function automatic logic [SEG_W-1:0] digit_pattern(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        case (d)
            4'd0:    p = 8'h3F;
            4'd1:    p = 8'h06;
            4'd2:    p = 8'h5B;
            4'd3:    p = 8'h4F;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'h6D;
            4'd6:    p = 8'h7D;
            4'd7:    p = 8'h07;
            4'd8:    p = 8'h7F;
            4'd9:    p = 8'h6F;
            default: p = SEG_BLANK;
        endcase
        return p;
    endfunction

    function automatic logic [SEG_W-1:0] select_byte(input logic [1:0] pos);
        logic [SEG_W-1:0] s;
        case (pos)
            2'd0:    s = 8'hF7;
            2'd1:    s = 8'hFB;
            2'd2:    s = 8'hFD;
            2'd3:    s = 8'hFE;
            default: s = 8'hFF;
        endcase
        return s;
    endfunction

endpackage

// File: sv/s7s_front.sv
// front end: takes a value, range-checks it, extracts decimal digits one per
// cycle and builds the four segment patterns; depends on s7s_pkg
`timescale 1ns / 1ps

module s7s_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic signed [31:0]    i_value,
    output logic                  o_push,
    input  logic                  i_full,
    output s7s_pkg::t_seg4        o_seg
);

    localparam int MW = s7s_pkg::MAG_W;

    s7s_pkg::t_front_state r_state, n_state;
    logic                  r_dec;
    logic                  r_mode_dec;
    logic                  r_neg;
    logic                  r_oor;
    logic [MW-1:0]         r_mag;
    logic [MW-1:0]         r_rest;
    logic [1:0]            r_cnt;
    logic [3:0]            r_dig [s7s_pkg::DIGITS];

    logic                  w_accept;
    logic                  w_oor;
    logic                  w_neg;
    logic [31:0]           w_abs;
    logic [MW+12:0]        w_prod;
    logic [MW-1:0]         w_quot;
    logic [MW-1:0]         w_rem;
    logic [2:0]            w_n;

    assign o_ready  = (r_state == s7s_pkg::ST_IDLE);
    assign w_accept = i_valid && o_ready;

    assign w_oor = (i_value > s7s_pkg::VALUE_MAX) || (i_value < s7s_pkg::VALUE_MIN);
    assign w_neg = i_value[31];
    assign w_abs = w_neg ? (32'd0 - i_value) : i_value;

    // divide by ten through the scaled reciprocal
    assign w_prod = (MW+13)'(r_rest) * (MW+13)'(s7s_pkg::RECIP_TEN);
    assign w_quot = MW'(w_prod[MW+12:16]);
    assign w_rem  = r_rest - ((w_quot << 3) + (w_quot << 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_dec <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode_dec <= i_cfg_wdata;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            s7s_pkg::ST_IDLE: begin
                if (w_accept) n_state = s7s_pkg::ST_CONV;
            end
            s7s_pkg::ST_CONV: begin
                if (r_cnt == 2'd3) n_state = s7s_pkg::ST_PUSH;
            end
            s7s_pkg::ST_PUSH: begin
                if (!i_full) n_state = s7s_pkg::ST_IDLE;
            end
            default: n_state = s7s_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= s7s_pkg::ST_IDLE;
            r_cnt   <= 2'd0;
        end else begin
            r_state <= n_state;
            if (r_state == s7s_pkg::ST_CONV) begin
                r_cnt <= r_cnt + 2'd1;
            end else begin
                r_cnt <= 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_oor  <= w_oor;
            r_neg  <= w_neg;
            r_dec  <= r_mode_dec;
            r_mag  <= w_abs[MW-1:0];
            r_rest <= w_abs[MW-1:0];
        end else if (r_state == s7s_pkg::ST_CONV) begin
            r_dig[r_cnt] <= w_rem[3:0];
            r_rest       <= w_quot;
        end
    end

    // count of shown digits, at least two in decimal mode
    always_comb begin
        if (r_mag < 14'd10)        w_n = 3'd1;
        else if (r_mag < 14'd100)  w_n = 3'd2;
        else if (r_mag < 14'd1000) w_n = 3'd3;
        else                       w_n = 3'd4;
        if (r_dec && w_n < 3'd2) w_n = 3'd2;
    end

    always_comb begin
        for (int i = 0; i < s7s_pkg::DIGITS; i++) begin
            if (r_oor) begin
                o_seg[i] = s7s_pkg::SEG_UNDERSCORE;
            end else if (3'(i) < w_n) begin
                o_seg[i] = s7s_pkg::digit_pattern(r_dig[i]);
                if (r_dec && i == 1) o_seg[i] = o_seg[i] | s7s_pkg::SEG_POINT;
            end else if (3'(i) == w_n && r_neg) begin
                o_seg[i] = s7s_pkg::SEG_MINUS;
            end else begin
                o_seg[i] = s7s_pkg::SEG_BLANK;
            end
        end
    end

    assign o_push = (r_state == s7s_pkg::ST_PUSH) && !i_full;

endmodule

// File: sv/s7s_fifo.sv
// short queue of segment pattern sets between front and back end
// depends on s7s_pkg
`timescale 1ns / 1ps

module s7s_fifo #(
    parameter int DEPTH = s7s_pkg::FIFO_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  s7s_pkg::t_seg4  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output s7s_pkg::t_seg4  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    s7s_pkg::t_seg4    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: sv/s7s_back.sv
// back end: shifts out four 16-bit frames per pattern set, one bit per item
// depends on s7s_pkg
`timescale 1ns / 1ps

module s7s_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  s7s_pkg::t_seg4  i_seg,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic            o_bit,
    output logic            o_latch,
    output logic            o_last
);

    localparam int CW = s7s_pkg::CNT_W;
    localparam logic [CW-1:0] LAST_CNT = CW'(s7s_pkg::BITS_PER_ITEM - 1);

    logic            r_active;
    logic [CW-1:0]   r_cnt;
    s7s_pkg::t_seg4  r_seg;

    logic            w_done;
    logic [1:0]      w_frame;
    logic [3:0]      w_pos;
    logic [7:0]      w_byte;

    assign w_done = r_active && i_tready && (r_cnt == LAST_CNT);
    assign o_pop  = i_valid && (!r_active || w_done);

    assign w_frame = r_cnt[5:4];
    assign w_pos   = r_cnt[3:0];
    assign w_byte  = w_pos[3] ? s7s_pkg::select_byte(w_frame) : r_seg[w_frame];

    // msb first within each byte
    assign o_tvalid = r_active;
    assign o_bit    = w_byte[~w_pos[2:0]];
    assign o_latch  = (w_pos == 4'hF);
    assign o_last   = (r_cnt == LAST_CNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (o_pop) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (w_done) begin
                r_active <= 1'b0;
            end else if (r_active && i_tready) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seg <= i_seg;
        end
    end

endmodule

// File: sv/signed_value_to_seven_segment_serial_unit.sv
// top level of the seven-segment serial unit: front end, queue, back end
// depends on s7s_pkg, s7s_front, s7s_fifo, s7s_back
//
//  channel   direction  payload                         item
//  s_axis    in         tdata[31:0] value (signed)      one value to show
//  m_axis    out        tdata[0] serial_bit, tuser      one serial bit,
//                       latch_after, tlast last         64 per value
//  cfg       in         wdata decimal_mode              write when idle
//
// each value yields 64 output items, one per cycle while tready is high, so
// the serialiser in the back end sets the rate at which values pass.
// the front end steps through accept, four digit steps and push per value
// and refills the queue while the back end shifts; back-pressure on m_axis
// fills the queue, then stalls s_axis.
// synchronous active-low reset clears control state and decimal_mode.
`timescale 1ns / 1ps

module signed_value_to_seven_segment_serial_unit #(
    parameter int FIFO_DEPTH = s7s_pkg::FIFO_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,     // [31:0] value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // [0] serial_bit, [7:1] zero
    output logic        m_axis_tuser,     // [0] latch_after
    output logic        m_axis_tlast
);

    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_q_valid;
    s7s_pkg::t_seg4  w_seg_in;
    s7s_pkg::t_seg4  w_seg_out;
    logic            w_bit;

    s7s_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_value     (signed'(s_axis_tdata)),
        .o_push      (w_push),
        .i_full      (w_full),
        .o_seg       (w_seg_in)
    );

    s7s_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_seg_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_seg_out)
    );

    s7s_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_q_valid),
        .i_seg    (w_seg_out),
        .o_pop    (w_pop),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_bit    (w_bit),
        .o_latch  (m_axis_tuser),
        .o_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, w_bit};

endmodule
